FILE: rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and register map of the relative deviation
// calibrator.
// ----------------------------------------------------------------------------
package rdc_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int RATE_W          = 16;
	localparam int RATE_SHIFT      = 10;
	localparam int SUM_W           = 24;
	localparam int CNT_W           = 8;
	localparam int CFG_ADDR_W      = 5;
	localparam int CFG_DATA_W      = 32;

	localparam logic [RATE_W-1:0] RATE_MAX = '1;

	localparam logic [RATE_W-1:0] MIN_RATE_RST  = 16'd8;
	localparam logic [RATE_W-1:0] FOLD_THR_RST  = 16'd250;
	localparam logic [RATE_W-1:0] FOLD_AMT_RST  = 16'd50;
	localparam logic [CNT_W-1:0]  TARGET_RST    = 8'd100;

	localparam logic [2:0] REG_BASELINE  = 3'd0;
	localparam logic [2:0] REG_MIN_RATE  = 3'd1;
	localparam logic [2:0] REG_FOLD_THR  = 3'd2;
	localparam logic [2:0] REG_FOLD_AMT  = 3'd3;
	localparam logic [2:0] REG_TARGET    = 3'd4;

	typedef struct packed {
		logic [RATE_W-1:0] baseline;
		logic [RATE_W-1:0] min_rate;
		logic [RATE_W-1:0] fold_threshold;
		logic [RATE_W-1:0] fold_amount;
		logic [CNT_W-1:0]  target_count;
	} rdc_cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rdc_div_status_t;

endpackage

FILE: rtl/rdc_if.sv
// ----------------------------------------------------------------------------
// rdc_if
// Valid/ready channels for microphone samples and calibration results.
// ----------------------------------------------------------------------------
interface rdc_sample_if import rdc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface rdc_result_if import rdc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] rate;
	logic              accepted;
	logic              finished;
	logic [RATE_W-1:0] average;

	modport source (output valid, output rate, output accepted, output finished,
		output average, input ready);
	modport sink (input valid, input rate, input accepted, input finished,
		input average, output ready);
endinterface

FILE: rtl/relative_deviation_calibrator.sv
// ----------------------------------------------------------------------------
// relative_deviation_calibrator
// Microphone calibration: relative deviation from a baseline, acceptance,
// folding and averaging of consecutive accepted rates.
// ----------------------------------------------------------------------------
// Samples arrive on a valid/ready channel; every sample transaction yields
// exactly one result transaction carrying the rate, the accepted flag, the
// finished flag and the latched average (zero until finished).
// Settings must be written through the APB port only while no sample is in
// flight; the block itself does not enforce this. One sample is processed at
// a time; samples is ready only while idle. The rate is |sample - baseline|
// * 1024 / baseline from a restoring divider that resolves one quotient bit
// per cycle. The rate is then evaluated and the result offered; a sample
// that completes the average first has the same divider form sum / count.
// A zero baseline skips the division and takes the maximum rate. A new
// sample is taken the cycle after the result transaction. While the receiver
// stalls, the result holds and no sample is accepted.
// Reset clears the running sum, count, finished flag and average and loads
// the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module relative_deviation_calibrator import rdc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rdc_sample_if.sink            samples,
	rdc_result_if.source          results,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int DEV_W = (SAMPLE_BITS > RATE_W) ? SAMPLE_BITS : RATE_W;
	localparam int DIV_W = DEV_W + RATE_SHIFT;

	typedef enum logic [2:0] {S_IDLE, S_RATE, S_EVAL, S_MEAN, S_OUT} state_t;

	state_t            state_q;
	rdc_cfg_t          cfg;
	rdc_div_status_t   div_st;
	logic [DIV_W-1:0]  div_q;
	logic [DIV_W-1:0]  div_dividend;
	logic [RATE_W-1:0] div_divisor;
	logic              div_start;

	logic [RATE_W-1:0] rate_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  count_q;
	logic              done_flag_q;
	logic [RATE_W-1:0] mean_q;
	logic              acc_q;

	logic              take;
	logic              base_zero;
	logic [DEV_W-1:0]  smp_ext;
	logic [DEV_W-1:0]  base_ext;
	logic [DEV_W-1:0]  dev;
	logic [RATE_W-1:0] rate_sat;
	logic [RATE_W-1:0] folded;
	logic [SUM_W-1:0]  sum_nxt;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [CNT_W-1:0]  goal;
	logic              reject;
	logic              finish_now;

	rdc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rdc_divider #(.DIVIDEND_W(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_q),
		.status   (div_st)
	);

	assign samples.ready = (state_q == S_IDLE);
	assign take          = samples.valid && samples.ready;
	assign base_zero     = (cfg.baseline == '0);

	assign smp_ext  = DEV_W'(samples.sample);
	assign base_ext = DEV_W'(cfg.baseline);
	assign dev      = (smp_ext > base_ext) ? (smp_ext - base_ext) : (base_ext - smp_ext);

	assign rate_sat = (|div_q[DIV_W-1:RATE_W]) ? RATE_MAX : div_q[RATE_W-1:0];

	assign reject = (rate_q < cfg.min_rate);
	always_comb begin
		folded = rate_q;
		if (rate_q >= cfg.fold_threshold) begin
			folded = (rate_q > cfg.fold_amount) ? (rate_q - cfg.fold_amount) : '0;
		end
	end
	assign sum_nxt    = sum_q + SUM_W'(folded);
	assign cnt_nxt    = count_q + 1'b1;
	assign goal       = (cfg.target_count == '0) ? CNT_W'(1) : cfg.target_count;
	assign finish_now = (cnt_nxt >= goal) && (cnt_nxt != '0);

	always_comb begin
		if (state_q == S_IDLE) begin
			div_dividend = {dev, {RATE_SHIFT{1'b0}}};
			div_divisor  = cfg.baseline;
			div_start    = take && !base_zero;
		end else begin
			div_dividend = DIV_W'(sum_nxt);
			div_divisor  = RATE_W'(cnt_nxt);
			div_start    = (state_q == S_EVAL) && !done_flag_q && !reject && finish_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rate_q      <= '0;
			sum_q       <= '0;
			count_q     <= '0;
			done_flag_q <= 1'b0;
			mean_q      <= '0;
			acc_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						acc_q <= 1'b0;
						if (base_zero) begin
							rate_q  <= RATE_MAX;
							state_q <= S_EVAL;
						end else begin
							state_q <= S_RATE;
						end
					end
				end
				S_RATE: begin
					if (div_st.done) begin
						rate_q  <= rate_sat;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (done_flag_q) begin
						state_q <= S_OUT;
					end else if (reject) begin
						sum_q   <= '0;
						count_q <= '0;
						state_q <= S_OUT;
					end else begin
						rate_q  <= folded;
						sum_q   <= sum_nxt;
						count_q <= cnt_nxt;
						acc_q   <= 1'b1;
						state_q <= finish_now ? S_MEAN : S_OUT;
					end
				end
				S_MEAN: begin
					if (div_st.done) begin
						mean_q      <= div_q[RATE_W-1:0];
						done_flag_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (results.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid    = (state_q == S_OUT);
	assign results.rate     = rate_q;
	assign results.accepted = acc_q;
	assign results.finished = done_flag_q;
	assign results.average  = done_flag_q ? mean_q : '0;

`ifndef SYNTHESIS
	a_out_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !div_st.busy)
		else $error("Result offered while the divider is busy.");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == S_RATE || state_q == S_MEAN))
		else $error("Divider finished outside a divide state.");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_flag_q |=> done_flag_q)
		else $error("Finished flag cleared without reset.");

	a_done_from_mean: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_flag_q) |-> $past(state_q) == S_MEAN)
		else $error("Finished flag set outside the averaging step.");

	a_no_accept_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && done_flag_q) |=> $stable(sum_q) && $stable(count_q))
		else $error("Running sum changed after calibration finished.");
`endif

endmodule

FILE: rtl/rdc_cfg.sv
// ----------------------------------------------------------------------------
// rdc_cfg
// APB-style register file holding the calibration settings.
// ----------------------------------------------------------------------------
module rdc_cfg import rdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output rdc_cfg_t              cfg
);

	rdc_cfg_t   cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[CFG_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.baseline       <= '0;
			cfg_q.min_rate       <= MIN_RATE_RST;
			cfg_q.fold_threshold <= FOLD_THR_RST;
			cfg_q.fold_amount    <= FOLD_AMT_RST;
			cfg_q.target_count   <= TARGET_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_BASELINE: cfg_q.baseline       <= pwdata[RATE_W-1:0];
				REG_MIN_RATE: cfg_q.min_rate       <= pwdata[RATE_W-1:0];
				REG_FOLD_THR: cfg_q.fold_threshold <= pwdata[RATE_W-1:0];
				REG_FOLD_AMT: cfg_q.fold_amount    <= pwdata[RATE_W-1:0];
				REG_TARGET:   cfg_q.target_count   <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BASELINE: prdata = CFG_DATA_W'(cfg_q.baseline);
			REG_MIN_RATE: prdata = CFG_DATA_W'(cfg_q.min_rate);
			REG_FOLD_THR: prdata = CFG_DATA_W'(cfg_q.fold_threshold);
			REG_FOLD_AMT: prdata = CFG_DATA_W'(cfg_q.fold_amount);
			REG_TARGET:   prdata = CFG_DATA_W'(cfg_q.target_count);
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: rtl/rdc_divider.sv
// ----------------------------------------------------------------------------
// rdc_divider
// Restoring divider producing one quotient bit per cycle, shared by the
// deviation rate and the average.
// ----------------------------------------------------------------------------
module rdc_divider import rdc_pkg::*; #(
	parameter int DIVIDEND_W = SAMPLE_BITS_DEF + RATE_SHIFT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [RATE_W-1:0]     divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output rdc_div_status_t       status
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] dvd_q;
	logic [RATE_W-1:0]     rem_q;
	logic [RATE_W-1:0]     dsr_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [RATE_W:0]       trial;
	logic [RATE_W:0]       diff;
	logic                  fits;

	assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

FILE: tb/sv/relative_deviation_calibrator_tb.sv
// ----------------------------------------------------------------------------
// relative_deviation_calibrator_tb
// Self-checking testbench for the relative deviation calibrator. A queue of
// microphone samples feeds a valid/ready driver, and a predictor computes the
// expected rate, accepted flag, finished flag and average for each sample
// transaction. A monitor compares each result transaction with the oldest
// prediction. Settings go through the APB port between phases and are read
// back. Directed samples hit zero and saturated rates, folding and the target
// count corners. Random phases then vary baselines, thresholds and handshake
// idling, and a final run lowers the target to finish the average.
// ----------------------------------------------------------------------------
module relative_deviation_calibrator_tb import rdc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 60;
	localparam int MAX_REPORTS = 50;

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic              accepted;
		logic              finished;
		logic [RATE_W-1:0] average;
	} cal_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	rdc_sample_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) smp_ch ();
	rdc_result_if res_ch ();

	relative_deviation_calibrator #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_ch),
		.results (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	logic [RATE_W-1:0] sample_backlog[$];
	cal_result_t due_results[$];

	rdc_cfg_t cal_cfg;
	logic [SUM_W-1:0] run_sum;
	logic [CNT_W-1:0] acc_cnt;
	logic cal_done;
	logic [RATE_W-1:0] mean_lat;

	int src_idle_pct;
	int sink_stall_pct;
	int hold_reqs;
	int hold_seen;
	int hold_left;
	int quiet_cycles;
	int error_count;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < MAX_REPORTS) begin
			$display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		end
		error_count++;
	endtask

	task automatic predict_calibration(input logic [RATE_W-1:0] smp, output cal_result_t r);
		logic [RATE_W-1:0] dev;
		logic [RATE_W+RATE_SHIFT-1:0] quot;
		logic [RATE_W-1:0] rt;
		logic [CNT_W-1:0] goal;
		logic [SUM_W-1:0] sum_div;
		r = '0;
		if (cal_cfg.baseline == '0) begin
			rt = RATE_MAX;
		end else begin
			dev = (smp > cal_cfg.baseline) ? smp - cal_cfg.baseline : cal_cfg.baseline - smp;
			quot = {dev, {RATE_SHIFT{1'b0}}} / cal_cfg.baseline;
			rt = (quot > RATE_MAX) ? RATE_MAX : quot[RATE_W-1:0];
		end
		if (!cal_done) begin
			if (rt < cal_cfg.min_rate) begin
				run_sum = '0;
				acc_cnt = '0;
			end else begin
				goal = (cal_cfg.target_count == '0) ? CNT_W'(1) : cal_cfg.target_count;
				if (rt >= cal_cfg.fold_threshold) begin
					rt = (rt > cal_cfg.fold_amount) ? rt - cal_cfg.fold_amount : '0;
				end
				r.accepted = 1'b1;
				run_sum = run_sum + SUM_W'(rt);
				acc_cnt = acc_cnt + 1'b1;
				if (acc_cnt >= goal && acc_cnt != '0) begin
					sum_div = run_sum / acc_cnt;
					mean_lat = sum_div[RATE_W-1:0];
					cal_done = 1'b1;
				end
			end
		end
		r.rate = rt;
		r.finished = cal_done;
		r.average = cal_done ? mean_lat : '0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] mirror_of(input logic [2:0] idx);
		case (idx)
			REG_BASELINE: return CFG_DATA_W'(cal_cfg.baseline);
			REG_MIN_RATE: return CFG_DATA_W'(cal_cfg.min_rate);
			REG_FOLD_THR: return CFG_DATA_W'(cal_cfg.fold_threshold);
			REG_FOLD_AMT: return CFG_DATA_W'(cal_cfg.fold_amount);
			REG_TARGET:   return CFG_DATA_W'(cal_cfg.target_count);
			default:      return '0;
		endcase
	endfunction

	function automatic logic [RATE_W-1:0] pick_sample(input logic [RATE_W-1:0] base);
		logic [RATE_W-1:0] off;
		off = RATE_W'($urandom_range(0, int'(base >> $urandom_range(2, 10))));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				if ($urandom_range(0, 1) && (RATE_MAX - base) >= off) begin
					return base + off;
				end else if (base >= off) begin
					return base - off;
				end else begin
					return base + off;
				end
			end
			5, 6, 7: return RATE_W'($urandom());
			8: return '0;
			default: return RATE_MAX;
		endcase
	endfunction

	// Register mirror used by the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_cfg.baseline <= '0;
			cal_cfg.min_rate <= MIN_RATE_RST;
			cal_cfg.fold_threshold <= FOLD_THR_RST;
			cal_cfg.fold_amount <= FOLD_AMT_RST;
			cal_cfg.target_count <= TARGET_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[CFG_ADDR_W-1:2])
				REG_BASELINE: cal_cfg.baseline <= pwdata[RATE_W-1:0];
				REG_MIN_RATE: cal_cfg.min_rate <= pwdata[RATE_W-1:0];
				REG_FOLD_THR: cal_cfg.fold_threshold <= pwdata[RATE_W-1:0];
				REG_FOLD_AMT: cal_cfg.fold_amount <= pwdata[RATE_W-1:0];
				REG_TARGET:   cal_cfg.target_count <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sample driver; the prediction is made when the transaction completes.
	always @(posedge clk or negedge arst_n) begin
		cal_result_t exp_r;
		if (!arst_n) begin
			smp_ch.valid <= 1'b0;
			smp_ch.sample <= '0;
			run_sum = '0;
			acc_cnt = '0;
			cal_done = 1'b0;
			mean_lat = '0;
		end else if (!smp_ch.valid || smp_ch.ready) begin
			if (smp_ch.valid) begin
				predict_calibration(smp_ch.sample, exp_r);
				due_results.push_back(exp_r);
			end
			if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				smp_ch.valid <= 1'b1;
				smp_ch.sample <= sample_backlog.pop_front();
			end else begin
				smp_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_reqs) begin
			hold_left <= HOLD_CYCLES;
			hold_seen <= hold_reqs;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		cal_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result transaction with nothing pending, rate", res_ch.rate, 0);
			end else begin
				want = due_results.pop_front();
				if (res_ch.rate !== want.rate)
					report_mismatch("rate", res_ch.rate, want.rate);
				if (res_ch.accepted !== want.accepted)
					report_mismatch("accepted", res_ch.accepted, want.accepted);
				if (res_ch.finished !== want.finished)
					report_mismatch("finished", res_ch.finished, want.finished);
				if (res_ch.average !== want.average)
					report_mismatch("average", res_ch.average, want.average);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (psel && penable)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic cfg_write(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_registers();
		logic [CFG_DATA_W-1:0] got;
		for (int i = REG_BASELINE; i <= REG_TARGET; i++) begin
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {3'(i), 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			got = prdata;
			psel <= 1'b0;
			penable <= 1'b0;
			if (got !== mirror_of(3'(i)))
				report_mismatch($sformatf("register %0d readback", i), got, mirror_of(3'(i)));
		end
	endtask

	// Upper data bits carry noise; the block keeps only the register width.
	task automatic set_config(input logic [RATE_W-1:0] base, input logic [RATE_W-1:0] minr,
			input logic [RATE_W-1:0] thr, input logic [RATE_W-1:0] amt);
		cfg_write(REG_BASELINE, {16'($urandom()), base});
		cfg_write(REG_MIN_RATE, {16'($urandom()), minr});
		cfg_write(REG_FOLD_THR, {16'($urandom()), thr});
		cfg_write(REG_FOLD_AMT, {16'($urandom()), amt});
	endtask

	task automatic set_target(input logic [CNT_W-1:0] tgt);
		cfg_write(REG_TARGET, {24'($urandom()), tgt});
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (sample_backlog.size() != 0 || smp_ch.valid || due_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		int n;
		logic [RATE_W-1:0] base;
		logic [RATE_W-1:0] minr;
		logic [RATE_W-1:0] thr;
		logic [RATE_W-1:0] amt;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp_ch.valid = 1'b0;
		smp_ch.sample = '0;
		res_ch.ready = 1'b0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_reqs = 0;
		quiet_cycles = 0;
		error_count = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Register defaults, zero baseline saturates every rate.
		check_registers();
		@(negedge clk);
		sample_backlog.push_back('0);
		sample_backlog.push_back(RATE_MAX);
		sample_backlog.push_back(16'h5555);
		wait_drained();

		set_config(16'd1000, 16'd8, 16'd250, 16'd50);
		set_target(8'd255);
		check_registers();
		@(negedge clk);
		sample_backlog.push_back(16'd1000);
		sample_backlog.push_back(16'd1001);
		sample_backlog.push_back(16'd1008);
		sample_backlog.push_back(16'd1250);
		sample_backlog.push_back(16'd999);
		sample_backlog.push_back('0);
		sample_backlog.push_back(RATE_MAX);
		wait_drained();

		// Largest and smallest nonzero baselines.
		cfg_write(REG_BASELINE, CFG_DATA_W'(RATE_MAX));
		@(negedge clk);
		sample_backlog.push_back('0);
		sample_backlog.push_back(RATE_MAX);
		sample_backlog.push_back(16'd32768);
		wait_drained();
		cfg_write(REG_BASELINE, CFG_DATA_W'(1));
		@(negedge clk);
		sample_backlog.push_back(RATE_MAX);
		sample_backlog.push_back(16'd1);
		sample_backlog.push_back('0);
		sample_backlog.push_back(16'd2);
		wait_drained();

		// Fold amount larger than the rate clamps to zero.
		set_config(16'd1000, 16'd0, 16'd0, RATE_MAX);
		@(negedge clk);
		sample_backlog.push_back(16'd1000);
		sample_backlog.push_back(16'd1500);
		wait_drained();

		// Folded rate drops under the minimum yet stays accepted.
		set_config(16'd1024, 16'd100, 16'd100, 16'd60);
		@(negedge clk);
		sample_backlog.push_back(16'd1124);
		sample_backlog.push_back(16'd1123);
		wait_drained();

		for (int i = REG_TARGET + 1; i < (1 << 3); i++) begin
			cfg_write(3'(i), $urandom());
		end
		check_registers();

		// Target of one with only rejected samples, so the run cannot finish.
		set_config(16'd1000, RATE_MAX, 16'd250, 16'd50);
		@(negedge clk);
		sample_backlog.push_back(16'd1000);
		wait_drained();
		set_target(8'd1);
		check_registers();
		@(negedge clk);
		sample_backlog.push_back(16'd1000);
		sample_backlog.push_back(16'd1005);
		sample_backlog.push_back(16'd40000);
		wait_drained();
		set_target(8'd255);

		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(0, 5))
				0: base = '0;
				1: base = 16'($urandom_range(1, 64));
				2: base = RATE_MAX;
				default: base = 16'($urandom_range(1, 65535));
			endcase
			case ($urandom_range(0, 4))
				0: minr = '0;
				1: minr = 16'($urandom_range(0, 32));
				2: minr = RATE_MAX;
				default: minr = 16'($urandom_range(0, 1024));
			endcase
			case ($urandom_range(0, 4))
				0: thr = '0;
				1: thr = RATE_MAX;
				default: thr = 16'($urandom_range(0, 2000));
			endcase
			amt = ($urandom_range(0, 5) == 0) ? RATE_MAX : 16'($urandom_range(0, 2000));
			// Keep the count well away from the target until the final run.
			if (acc_cnt > 8'd100) begin
				if (base == '0) base = 16'd1;
				if (minr == '0) minr = 16'd1;
			end
			set_config(base, minr, thr, amt);
			check_registers();
			@(negedge clk);
			case (p % 4)
				0: begin src_idle_pct = 0; sink_stall_pct = 0; end
				1: begin src_idle_pct = 57; sink_stall_pct = 0; end
				2: begin src_idle_pct = 0; sink_stall_pct = 57; end
				default: begin src_idle_pct = 24; sink_stall_pct = 24; end
			endcase
			if (acc_cnt > 8'd100) sample_backlog.push_back(base);
			n = $urandom_range(40, 80);
			for (int k = 0; k < n; k++) begin
				sample_backlog.push_back(pick_sample(base));
			end
			if (p == 4) hold_reqs <= hold_reqs + 1;
			wait_drained();
		end

		// Final run: fresh accumulation, then the target is lowered to zero.
		base = 16'($urandom_range(1000, 40000));
		set_config(base, 16'd1, 16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)));
		@(negedge clk);
		src_idle_pct = 24;
		sink_stall_pct = 24;
		sample_backlog.push_back(base);
		wait_drained();
		cfg_write(REG_MIN_RATE, '0);
		@(negedge clk);
		for (int k = 0; k < 80; k++) begin
			sample_backlog.push_back(16'($urandom()));
		end
		wait_drained();
		set_target('0);
		check_registers();
		@(negedge clk);
		sample_backlog.push_back(16'($urandom()));
		wait_drained();

		// Once finished, rates are still reported and nothing else moves.
		for (int k = 0; k < 15; k++) begin
			sample_backlog.push_back(pick_sample(base));
		end
		wait_drained();
		base = 16'($urandom());
		set_config(base, 16'($urandom_range(0, 64)), 16'($urandom_range(0, 500)),
			16'($urandom_range(0, 500)));
		set_target(8'd100);
		@(negedge clk);
		for (int k = 0; k < 15; k++) begin
			sample_backlog.push_back(pick_sample(base));
		end
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
